FILE: rtl/bst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

  localparam int unsigned MaxBlockRows = 256;
  localparam int unsigned MaxBlocks    = 4096;
  localparam int unsigned BlockSize    = 4;
  localparam int unsigned ValWords     = MaxBlocks * BlockSize * BlockSize;
  localparam int unsigned PtrDepth     = MaxBlockRows + 1;
  localparam int unsigned SolDepth     = MaxBlockRows * BlockSize;

  localparam int unsigned ValAw = $clog2(ValWords);
  localparam int unsigned BlkAw = $clog2(MaxBlocks);
  localparam int unsigned PtrAw = $clog2(PtrDepth);
  localparam int unsigned SolAw = $clog2(SolDepth);

  typedef enum logic [2:0] {
    CMD_VALUE    = 3'd0,
    CMD_COLUMN   = 3'd1,
    CMD_ROWSTART = 3'd2,
    CMD_DIAG     = 3'd3,
    CMD_RHS      = 3'd4,
    CMD_SOLVE    = 3'd5,
    CMD_READ     = 3'd6
  } cmd_e;

  localparam logic [1:0] StRead  = 2'd0;
  localparam logic [1:0] StClean = 2'd1;
  localparam logic [1:0] StSat   = 2'd2;

  // tag that travels with each product through the multiply-accumulate pipe
  typedef struct packed {
    logic       v;
    logic       first;
    logic       last;
    logic [1:0] row;
  } mac_tag_t;

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    logic ovf;
    ovf = !((&v[50:31]) || (~|v[50:31]));
    if (!ovf) return v[31:0];
    else if (v[50]) return 32'h8000_0000;
    else return 32'h7fff_ffff;
  endfunction

  function automatic logic ovf32(input logic signed [50:0] v);
    return !((&v[50:31]) || (~|v[50:31]));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bst_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module bst_mac (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [31:0]       a_i,
  input  wire logic signed [31:0]       b_i,
  input  wire bst_pkg::mac_tag_t        tag_i,
  output logic signed [65:0]            acc_o,
  output bst_pkg::mac_tag_t             done_o
);
  import bst_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q, acc_d;
  mac_tag_t           tb_q, done_q, done_d;

  // register the product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // accumulate four products per row, clear on the first
  always_comb begin
    acc_d  = (tb_q.first ? 66'sd0 : acc_q) + {{2{prod_q[63]}}, prod_q};
    done_d = tb_q;
    done_d.v = tb_q.v && tb_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q   <= '0;
      done_q <= '0;
    end else begin
      tb_q   <= tag_i;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_q.v) acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: rtl/block4_sparse_transpose_trisolve.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   command_i address_i data_value_i data_index_i
// out      output     out_valid_o / out_stall_i x_value_o status_o
// cfg      input      cfg_we_i                  cfg_wdata_i (num_block_rows)
// Loads are written as they are accepted; a read answers in the next cycle, one per cycle while out_stall_i is low.
// During a solve one shared multiplier does the 16 products of each block, one per cycle.
// Reset clears control state only; the stores hold garbage until loaded.
// Requests stall while a solve runs or while an undelivered result is stalled.
module block4_sparse_transpose_trisolve (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [8:0]          cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [2:0]          command_i,
  input  wire logic [15:0]         address_i,
  input  wire logic signed [31:0]  data_value_i,
  input  wire logic [12:0]         data_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       x_value_o,
  output logic [1:0]               status_o
);
  import bst_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_FP0  = 15'h0002,
    S_FP1  = 15'h0004,
    S_FP2  = 15'h0008,
    S_FCHK = 15'h0010,
    S_FWB  = 15'h0020,
    S_BP0  = 15'h0040,
    S_BP1  = 15'h0080,
    S_BP2  = 15'h0100,
    S_BCHK = 15'h0200,
    S_COL  = 15'h0400,
    S_COLW = 15'h0800,
    S_LD   = 15'h1000,
    S_DOT  = 15'h2000,
    S_DONE = 15'h4000
  } state_e;

  // stores
  logic [31:0] val_mem [ValWords];
  logic [7:0]  col_mem [MaxBlocks];
  logic [12:0] rs_mem  [PtrDepth];
  logic [12:0] dg_mem  [PtrDepth];
  logic [31:0] sol_mem [SolDepth];

  logic [ValAw-1:0] val_ra;
  logic [BlkAw-1:0] col_ra;
  logic [PtrAw-1:0] ptr_ra;
  logic [SolAw-1:0] sol_ra, sol_wa;
  logic             sol_re, sol_we;
  logic [31:0]      sol_wd;
  logic [31:0]      val_rd_q, sol_rd_q;
  logic [7:0]       col_rd_q;
  logic [12:0]      rs_rd_q, dg_rd_q;

  state_e st_q, st_d;
  logic [8:0]  n_q, n_d, i_q, i_d;
  logic [12:0] q_q, q_d, lim_q, lim_d;
  logic [11:0] pos_q, pos_d;
  logic [9:0]  base_q, base_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        red_q, red_d, bwd_q, bwd_d, lds_q, lds_d;
  logic        sat_q, sat_d;
  logic signed [31:0] xv_q [BlockSize];
  logic signed [31:0] s_q  [BlockSize];
  logic        out_valid_q, out_valid_d, zero_q, zero_d;
  logic [1:0]  status_q, status_d;

  mac_tag_t    a_tag_q, a_tag_d, done_tag;
  logic [1:0]  a_c_q, a_c_d;
  logic signed [65:0] acc;
  logic signed [31:0] vec_op;
  logic signed [50:0] dot_w, diff_w;

  logic accept;
  cmd_e cmd;

  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = (st_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // value, column and pointer stores: load writes, free-running reads
  always_ff @(posedge clk_i) begin
    if (accept && cmd == CMD_VALUE) val_mem[address_i] <= data_value_i;
    val_rd_q <= val_mem[val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd == CMD_COLUMN && address_i[15:BlkAw] == '0)
      col_mem[address_i[BlkAw-1:0]] <= data_index_i[7:0];
    col_rd_q <= col_mem[col_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd == CMD_ROWSTART && address_i <= 16'(MaxBlockRows))
      rs_mem[address_i[PtrAw-1:0]] <= data_index_i;
    if (accept && cmd == CMD_DIAG && address_i <= 16'(MaxBlockRows))
      dg_mem[address_i[PtrAw-1:0]] <= data_index_i;
    rs_rd_q <= rs_mem[ptr_ra];
    dg_rd_q <= dg_mem[ptr_ra];
  end

  // solution store: read holds its data unless enabled, which keeps a stalled result
  always_ff @(posedge clk_i) begin
    if (sol_we) sol_mem[sol_wa] <= sol_wd;
    if (sol_re) sol_rd_q <= sol_mem[sol_ra];
  end

  // multiply-accumulate pipe
  assign vec_op = red_q ? s_q[a_c_q] : xv_q[a_c_q];

  bst_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (val_rd_q),
    .b_i    (vec_op),
    .tag_i  (a_tag_q),
    .acc_o  (acc),
    .done_o (done_tag)
  );

  assign dot_w  = {acc[65], acc[65:16]};
  assign diff_w = {{19{xv_q[done_tag.row][31]}}, xv_q[done_tag.row]} - dot_w;

  // sequencer
  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; q_d = q_q; lim_d = lim_q; pos_d = pos_q;
    base_d = base_q; cnt_d = cnt_q; red_d = red_q; bwd_d = bwd_q; lds_d = lds_q;
    sat_d = sat_q; a_tag_d = '0; a_c_d = a_c_q;
    out_valid_d = out_valid_q && out_stall_i; zero_d = zero_q; status_d = status_q;
    val_ra = {pos_q, cnt_q[3:0]};
    col_ra = pos_q;
    ptr_ra = i_q;
    sol_ra = base_q + {8'd0, cnt_q[1:0]};
    sol_re = 1'b0;
    sol_we = 1'b0;
    sol_wa = base_q + {8'd0, done_tag.row};
    sol_wd = sat32(diff_w);

    if (cfg_we_i) n_d = (cfg_wdata_i > 9'(MaxBlockRows)) ? 9'(MaxBlockRows) : cfg_wdata_i;

    // reduction result write-back and saturation tracking
    if (done_tag.v) begin
      if (red_q) begin
        sol_we = 1'b1;
        if (ovf32(diff_w)) sat_d = 1'b1;
      end else if (ovf32(dot_w)) begin
        sat_d = 1'b1;
      end
    end

    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_RHS: begin
              if (address_i[15:SolAw] == '0) begin
                sol_we = 1'b1;
                sol_wa = address_i[SolAw-1:0];
                sol_wd = data_value_i;
              end
            end
            CMD_READ: begin
              sol_re      = 1'b1;
              sol_ra      = address_i[SolAw-1:0];
              out_valid_d = 1'b1;
              zero_d      = (address_i[15:SolAw] != '0);
              status_d    = StRead;
            end
            CMD_SOLVE: begin
              sat_d = 1'b0;
              i_d   = '0;
              bwd_d = 1'b0;
              st_d  = (n_q == '0) ? S_DONE : S_FP0;
            end
            default: ;
          endcase
        end
      end
      S_FP0: st_d = S_FP1;
      S_FP1: begin
        ptr_ra = 9'(i_q + 9'd1);
        q_d    = dg_rd_q;
        pos_d  = dg_rd_q[11:0];
        st_d   = S_FP2;
      end
      S_FP2: begin
        lim_d  = dg_rd_q;
        base_d = {i_q[7:0], 2'b00};
        red_d  = 1'b0;
        lds_d  = 1'b0;
        cnt_d  = '0;
        st_d   = S_LD;
      end
      S_FCHK: begin
        if ({1'b0, q_q} > ({1'b0, lim_q} + 14'd1)) begin
          q_d   = q_q - 13'd1;
          pos_d = q_q[11:0] - 12'd1;
          st_d  = S_COL;
        end else begin
          cnt_d = '0;
          st_d  = S_FWB;
        end
      end
      S_FWB: begin
        sol_we = 1'b1;
        sol_wa = {i_q[7:0], cnt_q[1:0]};
        sol_wd = s_q[cnt_q[1:0]];
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd3) begin
          cnt_d = '0;
          if (9'(i_q + 9'd1) == n_q) begin
            i_d   = 9'(n_q - 9'd1);
            bwd_d = 1'b1;
            st_d  = S_BP0;
          end else begin
            i_d  = 9'(i_q + 9'd1);
            st_d = S_FP0;
          end
        end
      end
      S_BP0: st_d = S_BP1;
      S_BP1: begin
        ptr_ra = 9'(i_q + 9'd1);
        q_d    = rs_rd_q;
        st_d   = S_BP2;
      end
      S_BP2: begin
        lim_d  = rs_rd_q;
        base_d = {i_q[7:0], 2'b00};
        lds_d  = 1'b1;
        cnt_d  = '0;
        st_d   = S_LD;
      end
      S_BCHK: begin
        if (q_q < lim_q) begin
          pos_d = q_q[11:0];
          q_d   = q_q + 13'd1;
          st_d  = S_COL;
        end else if (i_q == '0) begin
          st_d = S_DONE;
        end else begin
          i_d  = 9'(i_q - 9'd1);
          st_d = S_BP0;
        end
      end
      S_COL: st_d = S_COLW;
      S_COLW: begin
        base_d = {col_rd_q, 2'b00};
        red_d  = 1'b1;
        lds_d  = 1'b0;
        cnt_d  = '0;
        st_d   = S_LD;
      end
      S_LD: begin
        sol_re = (cnt_q < 5'd4);
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          cnt_d = '0;
          st_d  = lds_q ? S_BCHK : S_DOT;
        end
      end
      S_DOT: begin
        if (cnt_q < 5'd16) begin
          a_tag_d.v     = 1'b1;
          a_tag_d.first = (cnt_q[1:0] == 2'd0);
          a_tag_d.last  = (cnt_q[1:0] == 2'd3);
          a_tag_d.row   = cnt_q[3:2];
          a_c_d         = cnt_q[1:0];
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd18) begin
          cnt_d = '0;
          st_d  = (red_q && bwd_q) ? S_BCHK : S_FCHK;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        zero_d      = 1'b1;
        status_d    = sat_q ? StSat : StClean;
        st_d        = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      n_q         <= 9'd1;
      i_q         <= '0;
      cnt_q       <= '0;
      red_q       <= 1'b0;
      bwd_q       <= 1'b0;
      lds_q       <= 1'b0;
      sat_q       <= 1'b0;
      a_tag_q     <= '0;
      out_valid_q <= 1'b0;
      zero_q      <= 1'b0;
      status_q    <= StRead;
    end else begin
      st_q        <= st_d;
      n_q         <= n_d;
      i_q         <= i_d;
      cnt_q       <= cnt_d;
      red_q       <= red_d;
      bwd_q       <= bwd_d;
      lds_q       <= lds_d;
      sat_q       <= sat_d;
      a_tag_q     <= a_tag_d;
      out_valid_q <= out_valid_d;
      zero_q      <= zero_d;
      status_q    <= status_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    lim_q  <= lim_d;
    pos_q  <= pos_d;
    base_q <= base_d;
    a_c_q  <= a_c_d;
    // capture each loaded solution entry in the cycle after its read
    if (st_q == S_LD && cnt_q != 5'd0) begin
      if (lds_q) s_q[cnt_q[1:0] - 2'd1]  <= sol_rd_q;
      else       xv_q[cnt_q[1:0] - 2'd1] <= sol_rd_q;
    end
    // diagonal product lands in s
    if (done_tag.v && !red_q) s_q[done_tag.row] <= sat32(dot_w);
  end

  assign out_valid_o = out_valid_q;
  assign x_value_o   = zero_q ? 32'sd0 : sol_rd_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

FILE: test/tb_block4_sparse_transpose_trisolve.sv
`timescale 1ns / 1ps
module tb_block4_sparse_transpose_trisolve;
  import bst_pkg::*;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 40;
  // solution entries loaded at start-up; every solve stays below this
  localparam int unsigned SolLoaded = 256;

  typedef struct {
    logic [2:0]         cmd;
    logic [15:0]        addr;
    logic signed [31:0] dv;
    logic [12:0]        di;
  } request_t;

  typedef struct {
    logic signed [31:0] x;
    logic [1:0]         status;
  } solve_result_t;

  typedef int quad_t [4];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic [15:0] address = '0;
  logic signed [31:0] data_value = '0;
  logic [12:0] data_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] x_value;
  logic [1:0] status;

  block4_sparse_transpose_trisolve dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .address_i   (address),
    .data_value_i(data_value),
    .data_index_i(data_index),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .x_value_o   (x_value),
    .status_o    (status)
  );

  // shadow copy of the solver stores
  int         val_mem [ValWords];
  logic [7:0] col_mem [MaxBlocks];
  int         rs_mem [PtrDepth];
  int         dg_mem [PtrDepth];
  int         sol_mem [SolDepth];
  bit         sat_flag;
  int         rows_cfg = 1;

  request_t      pending_reqs[$];
  solve_result_t expected_results[$];
  request_t      cur_req;
  int  errors = 0;
  int  cycles = 0;
  int  random_items = 0;
  bit  counting = 0;
  bit  req_taken = 0;
  bit  res_taken = 0;
  bit  long_hold = 0;
  bit  quiet_send = 0;
  bit  quiet_recv = 0;
  int  gap_left = 0;
  int  hold_left = 0;

  // clamp to 32 bits and flag saturation
  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  // floored Q16.16 dot product of one block row with a 4-vector
  function automatic longint block_row_dot(int blk, int r, quad_t v);
    logic signed [65:0] acc, a, b;
    int w;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      w = (blk * 16 + r * 4 + c) % ValWords;
      a = val_mem[w];
      b = v[c];
      acc += a * b;
    end
    return longint'(acc >>> 16);
  endfunction

  function automatic void reduce_block(int pos, quad_t s);
    int blk, col, k;
    blk = pos % ValWords;
    col = col_mem[blk % MaxBlocks];
    for (int r = 0; r < 4; r++) begin
      k = (col * 4 + r) % SolDepth;
      sol_mem[k] = clamp32(longint'(sol_mem[k]) - block_row_dot(blk, r, s));
    end
  endfunction

  function automatic void run_solve();
    quad_t xv, s;
    int d, dn;
    sat_flag = 0;
    for (int i = 0; i < rows_cfg; i++) begin
      d = dg_mem[i];
      dn = dg_mem[i + 1];
      for (int r = 0; r < 4; r++) xv[r] = sol_mem[(i * 4 + r) % SolDepth];
      for (int r = 0; r < 4; r++) s[r] = clamp32(block_row_dot(d, r, xv));
      for (int p = d - 1; p > dn; p--) reduce_block(p, s);
      for (int r = 0; r < 4; r++) sol_mem[(i * 4 + r) % SolDepth] = s[r];
    end
    for (int i = rows_cfg - 1; i >= 0; i--) begin
      for (int r = 0; r < 4; r++) s[r] = sol_mem[(i * 4 + r) % SolDepth];
      for (int p = rs_mem[i]; p < rs_mem[i + 1]; p++) reduce_block(p, s);
    end
  endfunction

  // update the shadow stores and queue the expected answer
  function automatic void apply_request(request_t q);
    solve_result_t e;
    case (q.cmd)
      CMD_VALUE:    val_mem[q.addr] = q.dv;
      CMD_COLUMN:   if (q.addr < MaxBlocks) col_mem[q.addr] = q.di[7:0];
      CMD_ROWSTART: if (q.addr < PtrDepth) rs_mem[q.addr] = q.di;
      CMD_DIAG:     if (q.addr < PtrDepth) dg_mem[q.addr] = q.di;
      CMD_RHS:      if (q.addr < SolDepth) sol_mem[q.addr] = q.dv;
      CMD_SOLVE: begin
        run_solve();
        e.x = '0;
        e.status = sat_flag ? StSat : StClean;
        expected_results.push_back(e);
      end
      CMD_READ: begin
        e.x = (q.addr < SolDepth) ? sol_mem[q.addr] : '0;
        e.status = StRead;
        expected_results.push_back(e);
      end
      default: ;
    endcase
  endfunction

  function automatic void push_req(logic [2:0] cmd, int addr, int dv, int di);
    request_t q;
    q.cmd = cmd;
    q.addr = addr[15:0];
    q.dv = dv;
    q.di = di[12:0];
    pending_reqs.push_back(q);
    if (counting) random_items++;
  endfunction

  // Q16.16 value: mostly within +-2.0, sometimes anything, sometimes an extreme
  function automatic int rand_q16(bit wide);
    int k;
    k = $urandom_range(0, 9);
    if (!wide || k < 7) return int'($urandom_range(0, 262144)) - 131072;
    if (k < 9) return int'($urandom);
    return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  // value word inside a block that was loaded at start-up
  function automatic int ready_word();
    if ($urandom_range(0, 3) == 0) return 65520 + $urandom_range(0, 15);
    return $urandom_range(0, 255);
  endfunction

  function automatic int ready_block();
    if ($urandom_range(0, 4) == 0) return 4095;
    return $urandom_range(0, 15);
  endfunction

  // column index with random upper bits; the kept byte stays inside the loaded entries
  function automatic int col_value();
    return int'(($urandom_range(0, 31) << 8) | $urandom_range(0, SolLoaded / 4 - 1));
  endfunction

  // one well-formed problem: pointers, some reloads, noise, a solve and reads
  function automatic void build_problem(int n, bit wide, int reads);
    int base, a;
    base = ($urandom_range(0, 2) == 0) ? 4095 : 0;
    for (int i = 0; i <= n; i++) begin
      if (i == n && $urandom_range(0, 1) != 0) push_req(CMD_DIAG, i, $urandom, $urandom_range(4200, 8191));
      else push_req(CMD_DIAG, i, $urandom, base + $urandom_range(1, 12));
      push_req(CMD_ROWSTART, i, $urandom, base + $urandom_range(0, 12));
    end
    for (int k = $urandom_range(0, 10); k > 0; k--)
      push_req(CMD_VALUE, ready_word(), rand_q16(wide), $urandom);
    for (int k = $urandom_range(0, 4); k > 0; k--)
      push_req(CMD_COLUMN, ready_block(), $urandom, col_value());
    for (int k = $urandom_range(0, 8); k > 0; k--)
      push_req(CMD_RHS, (n > 0 && $urandom_range(0, 1) != 0) ? $urandom_range(0, 4 * n - 1)
                        : $urandom_range(0, 1023), rand_q16(wide), $urandom);
    for (int k = $urandom_range(0, 3); k > 0; k--) begin
      case ($urandom_range(0, 4))
        0: push_req(CmdUnused, $urandom, $urandom, $urandom);
        1: push_req(CMD_COLUMN, $urandom_range(4096, 65535), $urandom, $urandom);
        2: push_req(CMD_ROWSTART, $urandom_range(257, 65535), $urandom, $urandom);
        3: push_req(CMD_DIAG, $urandom_range(257, 65535), $urandom, $urandom);
        default: push_req(CMD_RHS, $urandom_range(1024, 65535), $urandom, $urandom);
      endcase
    end
    push_req(CMD_SOLVE, $urandom, $urandom, $urandom);
    for (int k = 0; k < reads; k++) begin
      a = ($urandom_range(0, 7) == 0) ? $urandom_range(1024, 65535)
          : (n > 0 ? $urandom_range(0, 4 * n - 1) : $urandom_range(0, SolLoaded - 1));
      push_req(CMD_READ, a, $urandom, $urandom);
    end
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_rows(int v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v[8:0];
    rows_cfg = (v > MaxBlockRows) ? MaxBlockRows : v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // clock and reset
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // sample both handshakes
  always @(posedge clk_i) begin
    solve_result_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        res_taken = 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result x=%h status=%0d", $time, x_value, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (x_value !== e.x) begin
            $display("%0t: x_value expected %h actual %h", $time, e.x, x_value);
            errors++;
          end
          if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(cur_req);
        req_taken = 1;
      end
    end
  end

  // present requests with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (req_taken || !in_valid)) begin
      req_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        command <= cur_req.cmd;
        address <= cur_req.addr;
        data_value <= cur_req.dv;
        data_index <= cur_req.di;
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) quiet_send = !quiet_send;
        gap_left = quiet_send ? 0 : $urandom_range(0, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall the result side with random holds
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 0;
        if ($urandom_range(0, 99) == 0) quiet_recv = !quiet_recv;
        hold_left = quiet_recv ? 0 : $urandom_range(0, 18);
      end
      // start the long hold on the first result that shows up once armed
      if (long_hold && out_valid) begin
        long_hold = 0;
        hold_left = 400;
      end
      out_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  // abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("block4_sparse_transpose_trisolve test failed");
      $finish;
    end
  end

  initial begin
    int n;
    bit held;
    held = 0;
    @(posedge rst_ni);
    counting = 1;
    // load the right-hand side and the blocks that solves may touch
    for (int a = 0; a < SolLoaded; a++) push_req(CMD_RHS, a, rand_q16(0), $urandom);
    for (int a = 0; a < 256; a++) push_req(CMD_VALUE, a, rand_q16(0), $urandom);
    for (int a = 65520; a < 65536; a++) push_req(CMD_VALUE, a, rand_q16(0), $urandom);
    for (int b = 0; b < 16; b++) push_req(CMD_COLUMN, b, $urandom, col_value());
    push_req(CMD_COLUMN, 4095, $urandom, 13'h1f3f);
    // directed corner cases
    push_req(CMD_VALUE, 65535, 32'sh80000000, 0);
    push_req(CMD_VALUE, 0, 32'sh7fffffff, 8191);
    push_req(CmdUnused, 65535, -1, 8191);
    push_req(CMD_COLUMN, 4096, 0, 8191);
    push_req(CMD_ROWSTART, 257, 0, 8191);
    push_req(CMD_DIAG, 65535, 0, 8191);
    push_req(CMD_RHS, 1024, -1, 0);
    push_req(CMD_RHS, 1023, 32'sh80000000, 0);
    push_req(CMD_RHS, 0, 32'sh7fffffff, 0);
    push_req(CMD_READ, 1023, 0, 0);
    push_req(CMD_READ, 0, 0, 0);
    push_req(CMD_READ, 1024, 0, 0);
    push_req(CMD_READ, 65535, 0, 0);
    build_problem(1, 1, 4);
    wait_idle();
    // no block rows: solve does nothing
    write_rows(0);
    build_problem(0, 0, 2);
    wait_idle();
    // random problems; the first one backs up behind a long output hold
    while (random_items < 1000) begin
      case ($urandom_range(0, 19))
        0: n = 0;
        1: n = 16;
        2: n = $urandom_range(5, 40);
        default: n = $urandom_range(1, 4);
      endcase
      write_rows(n);
      if (!held) begin
        held = 1;
        long_hold = 1;
        build_problem(n, $urandom_range(0, 1), 40);
      end else begin
        build_problem(n, $urandom_range(0, 1), $urandom_range(1, 8));
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("block4_sparse_transpose_trisolve test passed");
    end else begin
      $display("block4_sparse_transpose_trisolve test failed");
    end
    $finish;
  end

endmodule
